FILE: src/wia_pkg.sv
`default_nettype none
package wia_pkg;
  localparam int unsigned EXP_BITS_DEF = 19;
  localparam logic [3:0] MODE_ADD  = 4'd0;
  localparam logic [3:0] MODE_SUB  = 4'd1;
  localparam logic [3:0] MODE_MUL  = 4'd2;
  localparam logic [3:0] MODE_SHL  = 4'd3;
  localparam logic [3:0] MODE_SHR  = 4'd4;
  localparam logic [3:0] MODE_CMP  = 4'd5;
  localparam logic [3:0] MODE_J256 = 4'd6;
  localparam logic [3:0] MODE_J320 = 4'd7;
  localparam logic [3:0] MODE_NORM = 4'd8;
endpackage
`default_nettype wire

FILE: src/wide_int_alu_256.sv
// wide_int_alu_256: 256-bit integer helper unit for octuple-precision float code.
// Input channel: in_valid/in_stall carry mode, a_w0..a_w3, b_w0..b_w3,
// shift_count and extra_in. Output channel: out_valid/out_stall carry
// r_w0..r_w3, extra_out, exponent_adjust and the compare/error flags.
// One transaction in gives one transaction out.
// Work is digit serial: a 320-bit working register moves one bit per cycle, except in mul.
// Every mode first runs an LSB-first pass over all 256 bits for the compare flags;
// add/sub produce their sum bits in the same pass.
// mul: 128 multiplier bits, each a 32-bit-digit add over four digits, then shift.
// shifts: one bit of shift at a time; shr and jam modes stop early once the
// value is zero; normalize shifts one place at a time.
// One transaction at a time: a new one is accepted only after the last has
// entered the output register.
// in_stall is high from acceptance until the result enters the output
// register; the result sits there while out_stall is high, and the next
// transaction may run meanwhile but cannot finish until it is taken.
// Synchronous reset drops out_valid and returns to idle.
`default_nettype none
module wide_int_alu_256 #(
  parameter int unsigned EXP_BITS = wia_pkg::EXP_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  mode,
  input  wire logic [63:0] a_w0, a_w1, a_w2, a_w3,
  input  wire logic [63:0] b_w0, b_w1, b_w2, b_w3,
  input  wire logic [8:0]  shift_count,
  input  wire logic [63:0] extra_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      r_w0, r_w1, r_w2, r_w3,
  output logic [63:0]      extra_out,
  output logic signed [8:0] exponent_adjust,
  output logic             is_equal, is_less, is_less_equal, error
);
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_DONE = 2'd2, S_CMP = 2'd3;
  logic [1:0]   state;
  logic [3:0]   op;
  logic [319:0] acc;     // working value; a in [319:64] for shifts
  logic [255:0] bop;     // b operand, rotates for serial add/compare
  logic [255:0] res;     // serial add result / mul product
  logic [8:0]   cnt;
  logic [8:0]   shamt;   // shift count, held through the compare pass
  logic [1:0]   dig;     // 32-bit digit index within one mul step
  logic         carry, sticky, eq, lt;
  logic [8:0]   lz;      // normalize: shifts done

  assign in_stall = (state != S_IDLE);
  logic sum_bit, cout, a0;
  assign a0 = acc[64];
  always_comb begin
    if (op == wia_pkg::MODE_SUB) begin
      sum_bit = a0 ^ ~bop[0] ^ carry;
      cout = (a0 & ~bop[0]) | (a0 & carry) | (~bop[0] & carry);
    end else begin
      sum_bit = a0 ^ bop[0] ^ carry;
      cout = (a0 & bop[0]) | (a0 & carry) | (bop[0] & carry);
    end
  end
  // multiply: acc[191:64] holds {a_hi,a_lo} as multiplier (shifted), res product;
  // res[255:128] gets the multiplicand added one 32-bit digit per cycle
  logic [32:0] dsum;
  assign dsum = {1'b0, res[159:128]} + {1'b0, (acc[64] ? bop[31:0] : 32'd0)}
              + {32'd0, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= mode;
            acc <= {a_w0, a_w1, a_w2, a_w3,
                    (mode == wia_pkg::MODE_J320) ? extra_in : 64'd0};
            bop <= {b_w0, b_w1, b_w2, b_w3};
            res <= '0;
            carry <= (mode == wia_pkg::MODE_SUB);
            sticky <= 1'b0; eq <= 1'b1; lt <= 1'b0; lz <= '0;
            cnt <= 9'd256;
            shamt <= shift_count;
            dig <= '0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (cnt == 9'd0) begin
            case (op)
              wia_pkg::MODE_ADD, wia_pkg::MODE_SUB, wia_pkg::MODE_CMP: state <= S_DONE;
              wia_pkg::MODE_MUL: begin
                cnt <= 9'd128;
                dig <= '0;
                carry <= 1'b0;
                state <= S_RUN;
              end
              wia_pkg::MODE_SHL, wia_pkg::MODE_SHR, wia_pkg::MODE_J256,
              wia_pkg::MODE_J320: begin
                cnt <= shamt;
                state <= S_RUN;
              end
              wia_pkg::MODE_NORM: state <= S_RUN;
              default: state <= S_DONE;
            endcase
          end else begin
            cnt <= cnt - 9'd1;
            // LSB-first compare: later (higher) bits override
            if (acc[64] != bop[0]) begin eq <= 1'b0; lt <= bop[0]; end
            if (op inside {wia_pkg::MODE_ADD, wia_pkg::MODE_SUB}) res <= {sum_bit, res[255:1]};
            carry <= cout;
            // full rotation: a and b are back in place once all 256 bits have gone round
            acc[319:64] <= {acc[64], acc[319:65]};
            bop <= {bop[0], bop[255:1]};
          end
        end
        S_RUN: begin
          case (op)
            wia_pkg::MODE_MUL: begin
              if (cnt == 9'd0) state <= S_DONE;
              else begin
                bop[127:0] <= {bop[31:0], bop[127:32]};
                if (dig == 2'd3) begin
                  // last digit, then shift {carry, hi, lo} right by one
                  res <= {dsum, res[255:160], res[127:1]};
                  carry <= 1'b0;
                  acc[191:64] <= {1'b0, acc[191:65]};
                  cnt <= cnt - 9'd1;
                end else begin
                  res[255:128] <= {dsum[31:0], res[255:160]};
                  carry <= dsum[32];
                end
                dig <= dig + 2'd1;
              end
            end
            wia_pkg::MODE_SHL: begin
              if (cnt == 9'd0) state <= S_DONE;
              else if (cnt >= 9'd256) begin acc <= '0; state <= S_DONE; end
              else begin acc[319:64] <= {acc[318:64], 1'b0}; cnt <= cnt - 9'd1; end
            end
            wia_pkg::MODE_SHR, wia_pkg::MODE_J256, wia_pkg::MODE_J320: begin
              if (cnt == 9'd0 || acc == '0) state <= S_DONE;
              else if (op == wia_pkg::MODE_SHR && cnt >= 9'd256) begin
                acc <= '0; state <= S_DONE;
              end else begin
                if (op == wia_pkg::MODE_J256) begin
                  sticky <= sticky | acc[64];
                  acc[319:64] <= {1'b0, acc[319:65]};
                end else begin
                  sticky <= sticky | acc[0];
                  acc <= {1'b0, acc[319:1]};
                end
                cnt <= cnt - 9'd1;
              end
            end
            wia_pkg::MODE_NORM: begin
              // shift until the leading one reaches the top EXP_BITS+1 window
              if (acc[319:64] == '0) state <= S_DONE;
              else if (|acc[319 -: EXP_BITS + 1]) state <= S_DONE;
              else begin
                acc[319:64] <= {acc[318:64], 1'b0};
                lz <= lz + 9'd1;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
    end
  end

  // output register, loaded as the run finishes
  logic [255:0] fin;
  logic [63:0]  fin_x;
  logic [8:0]   fin_adj;
  logic         fin_err;
  logic [8:0]   wlz;
  logic [8:0]   lz_tot;

  // leading zeros inside the top window (only used when no shift was done)
  always_comb begin
    wlz = '0;
    for (int i = int'(EXP_BITS); i >= 0; i--) begin
      if (acc[319 - i]) wlz = 9'(i);
    end
  end
  // after any shift the leading one sits exactly EXP_BITS below the top
  assign lz_tot = (lz != 9'd0) ? lz + 9'(EXP_BITS) : wlz;

  always_comb begin
    fin = '0; fin_x = '0; fin_adj = '0; fin_err = 1'b0;
    case (op)
      wia_pkg::MODE_ADD, wia_pkg::MODE_SUB: fin = res;
      wia_pkg::MODE_MUL: fin = res;
      wia_pkg::MODE_CMP: fin = '0;
      wia_pkg::MODE_SHL, wia_pkg::MODE_SHR: fin = acc[319:64];
      wia_pkg::MODE_J256: fin = {acc[319:65], acc[64] | sticky};
      wia_pkg::MODE_J320: begin
        fin = acc[319:64];
        fin_x = {acc[63:1], acc[0] | sticky};
      end
      wia_pkg::MODE_NORM: begin
        if (acc[319:64] == '0) fin_err = 1'b1;
        else begin
          fin = acc[319:64];
          fin_adj = 9'(1 + EXP_BITS) - lz_tot;
        end
      end
      default: fin_err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      {r_w0, r_w1, r_w2, r_w3} <= fin;
      extra_out <= fin_x;
      exponent_adjust <= fin_adj;
      error <= fin_err;
      is_equal <= eq;
      is_less <= lt;
      is_less_equal <= eq | lt;
    end
  end
endmodule
`default_nettype wire
